>>> sv/icmp_echo_reply_checker_macros.svh
// assertion macros shared by the icmp echo reply checker rtl
`ifndef ICMP_ECHO_REPLY_CHECKER_MACROS_SVH
`define ICMP_ECHO_REPLY_CHECKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define ICMPCHK_ASSERT_SAME(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("icmp checker assertion failed");

// next-cycle implication, disabled during reset
`define ICMPCHK_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("icmp checker assertion failed");

`endif

>>> sv/icmpchk_pkg.sv
// types and constants of the icmp echo reply checker
package icmpchk_pkg;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_TOO_SHORT   = 3'd1,
    STATUS_BAD_SUM     = 3'd2,
    STATUS_NOT_REPLY   = 3'd3,
    STATUS_FOREIGN_ID  = 3'd4
  } status_t;

  localparam logic [16:0] ECHO_HEADER_LEN = 17'd8;
  localparam logic [7:0]  ECHO_REPLY_TYPE = 8'd0;
  localparam logic [31:0] MIN_TRIP_RESET  = 32'd65535;
  localparam logic [15:0] POSITION_MAX    = 16'hffff;
  localparam logic [15:0] SUM_ALL_ONES    = 16'hffff;

  // icmp field offsets
  localparam logic [15:0] OFF_TYPE     = 16'd0;
  localparam logic [15:0] OFF_ID_LO    = 16'd4;
  localparam logic [15:0] OFF_ID_HI    = 16'd5;
  localparam logic [15:0] OFF_SEQ_LO   = 16'd6;
  localparam logic [15:0] OFF_SEQ_HI   = 16'd7;
  localparam logic [15:0] OFF_TS_FIRST = 16'd8;
  localparam logic [15:0] OFF_TS_LAST  = 16'd11;

endpackage

>>> sv/icmp_echo_reply_checker.sv
// icmp echo reply checker: byte parser, checksum and round-trip statistics
//
// Input channel (in_valid/in_ready) takes one IPv4 packet byte per transfer
// with last_byte marking the final byte; now_ms is sampled on that byte.
// Output channel (out_valid/out_ready) gives one result per packet: status,
// type, sequence, round trip, payload length and the running statistics.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes own_identifier and is
// always ready; that it is written only while no packet is in flight is up
// to the user, not enforced. Throughput: one byte per cycle while the output
// is not stalled, set by the per-byte parse and 16-bit sum stage. A last byte's
// result is registered after parse, checksum fold and length checks, and decision.
// When the output is stalled the whole pipeline holds and in_ready drops;
// it rises again in the cycle the waiting result is taken.
// Reset (rst, synchronous) clears the parse state, empties the pipeline,
// sets own_identifier to 0 and the statistics to count 0, minimum 65535,
// maximum 0 and total 0.
`include "icmp_echo_reply_checker_macros.svh"

module icmp_echo_reply_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  reply_type,
  output logic [15:0] sequence_res,
  output logic [31:0] round_trip_ms,
  output logic [15:0] payload_length,
  output logic [31:0] replies_received,
  output logic [31:0] least_round_trip,
  output logic [31:0] greatest_round_trip,
  output logic [31:0] summed_round_trip
);

  logic        stall;
  logic        in_xfer;
  logic [15:0] own_identifier;

  // packet parse state
  logic [15:0] byte_position;
  logic [5:0]  header_bytes;
  logic [15:0] declared_length;
  logic [31:0] sum_accumulator;
  logic [7:0]  held_high_byte;
  logic [7:0]  seen_type;
  logic [15:0] seen_identifier;
  logic [15:0] seen_sequence;
  logic [31:0] seen_timestamp;

  logic [5:0]  header_bytes_next;
  logic [15:0] declared_length_next;
  logic [31:0] sum_accumulator_next;
  logic [7:0]  held_high_byte_next;
  logic [7:0]  seen_type_next;
  logic [15:0] seen_identifier_next;
  logic [15:0] seen_sequence_next;
  logic [31:0] seen_timestamp_next;
  logic [15:0] byte_position_next;
  logic        take_icmp;
  logic [15:0] icmp_off;

  // stage 1: snapshot of a finished packet
  logic        s1_valid;
  logic [16:0] s1_received;
  logic [5:0]  s1_header;
  logic [15:0] s1_length;
  logic [31:0] s1_sum;
  logic        s1_odd;
  logic [7:0]  s1_held;
  logic [7:0]  s1_type;
  logic [15:0] s1_ident;
  logic [15:0] s1_seq;
  logic [31:0] s1_stamp;
  logic [31:0] s1_now;

  // stage 2: length checks, first fold, round trip
  logic        s2_valid;
  logic        s2_short;
  logic [15:0] s2_payload;
  logic [16:0] s2_fold;
  logic [31:0] s2_trip;
  logic [7:0]  s2_type;
  logic [15:0] s2_ident;
  logic [15:0] s2_seq;

  logic [31:0] padded_sum;
  logic        short_next;

  // decision stage
  logic [16:0] fold_final;
  logic        sum_good;
  logic [2:0]  status_next;
  logic        good_next;

  logic [31:0] good_count;
  logic [31:0] minimum_trip;
  logic [31:0] maximum_trip;
  logic [31:0] total_trip;

  assign stall     = out_valid && !out_ready;
  assign in_ready  = !stall;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_identifier <= '0;
    end else if (cfg_valid && cfg_ready) begin
      own_identifier <= cfg_data;
    end
  end

  // per-byte parse
  always_comb begin
    header_bytes_next    = header_bytes;
    declared_length_next = declared_length;
    sum_accumulator_next = sum_accumulator;
    held_high_byte_next  = held_high_byte;
    seen_type_next       = seen_type;
    seen_identifier_next = seen_identifier;
    seen_sequence_next   = seen_sequence;
    seen_timestamp_next  = seen_timestamp;

    if (byte_position == 16'd0) begin
      header_bytes_next = {data_byte[3:0], 2'b00};
    end
    if (byte_position == 16'd2) begin
      declared_length_next = {data_byte, declared_length[7:0]};
    end
    if (byte_position == 16'd3) begin
      declared_length_next = {declared_length[15:8], data_byte};
    end

    // header can be shorter than 4 bytes, so bytes 0..3 may be icmp bytes
    take_icmp = (byte_position >= {10'd0, header_bytes_next}) &&
                ((byte_position < 16'd4) || (byte_position < declared_length_next));
    icmp_off  = byte_position - {10'd0, header_bytes_next};

    if (take_icmp) begin
      if (icmp_off[0]) begin
        sum_accumulator_next = sum_accumulator + {16'd0, held_high_byte, data_byte};
      end else begin
        held_high_byte_next = data_byte;
      end
      if (icmp_off == icmpchk_pkg::OFF_TYPE) begin
        seen_type_next = data_byte;
      end else if (icmp_off == icmpchk_pkg::OFF_ID_LO) begin
        seen_identifier_next = {seen_identifier[15:8], data_byte};
      end else if (icmp_off == icmpchk_pkg::OFF_ID_HI) begin
        seen_identifier_next = {data_byte, seen_identifier[7:0]};
      end else if (icmp_off == icmpchk_pkg::OFF_SEQ_LO) begin
        seen_sequence_next = {seen_sequence[15:8], data_byte};
      end else if (icmp_off == icmpchk_pkg::OFF_SEQ_HI) begin
        seen_sequence_next = {data_byte, seen_sequence[7:0]};
      end else if (icmp_off >= icmpchk_pkg::OFF_TS_FIRST &&
                   icmp_off <= icmpchk_pkg::OFF_TS_LAST) begin
        // timestamp is little-endian
        case (icmp_off[1:0])
          2'd0:    seen_timestamp_next[7:0]   = data_byte;
          2'd1:    seen_timestamp_next[15:8]  = data_byte;
          2'd2:    seen_timestamp_next[23:16] = data_byte;
          default: seen_timestamp_next[31:24] = data_byte;
        endcase
      end
    end

    if (byte_position == icmpchk_pkg::POSITION_MAX) begin
      byte_position_next = byte_position;
    end else begin
      byte_position_next = byte_position + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      header_bytes    <= '0;
      declared_length <= '0;
      sum_accumulator <= '0;
      held_high_byte  <= '0;
      seen_type       <= '0;
      seen_identifier <= '0;
      seen_sequence   <= '0;
      seen_timestamp  <= '0;
    end else if (in_xfer) begin
      if (last_byte) begin
        byte_position   <= '0;
        header_bytes    <= '0;
        declared_length <= '0;
        sum_accumulator <= '0;
        held_high_byte  <= '0;
        seen_type       <= '0;
        seen_identifier <= '0;
        seen_sequence   <= '0;
        seen_timestamp  <= '0;
      end else begin
        byte_position   <= byte_position_next;
        header_bytes    <= header_bytes_next;
        declared_length <= declared_length_next;
        sum_accumulator <= sum_accumulator_next;
        held_high_byte  <= held_high_byte_next;
        seen_type       <= seen_type_next;
        seen_identifier <= seen_identifier_next;
        seen_sequence   <= seen_sequence_next;
        seen_timestamp  <= seen_timestamp_next;
      end
    end
  end

  // stage 1 load
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= in_xfer && last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_received <= {1'b0, byte_position} + 17'd1;
      s1_header   <= header_bytes_next;
      s1_length   <= declared_length_next;
      s1_sum      <= sum_accumulator_next;
      // header length is a multiple of four, so the icmp length parity is that of total
      s1_odd      <= declared_length_next[0];
      s1_held     <= held_high_byte_next;
      s1_type     <= seen_type_next;
      s1_ident    <= seen_identifier_next;
      s1_seq      <= seen_sequence_next;
      s1_stamp    <= seen_timestamp_next;
      s1_now      <= now_ms;
    end
  end

  // stage 2: pad odd byte, first fold, length checks
  always_comb begin
    padded_sum = s1_sum + (s1_odd ? {16'd0, s1_held, 8'd0} : 32'd0);
    short_next = ({1'b0, s1_length} < ({11'd0, s1_header} + icmpchk_pkg::ECHO_HEADER_LEN)) ||
                 (s1_received < {1'b0, s1_length});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!stall) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s2_short   <= short_next;
      s2_payload <= short_next ? 16'd0 :
                    (s1_length - {10'd0, s1_header} - icmpchk_pkg::ECHO_HEADER_LEN[15:0]);
      s2_fold    <= {1'b0, padded_sum[31:16]} + {1'b0, padded_sum[15:0]};
      s2_trip    <= s1_now - s1_stamp;
      s2_type    <= s1_type;
      s2_ident   <= s1_ident;
      s2_seq     <= s1_seq;
    end
  end

  // decision
  always_comb begin
    fold_final = {1'b0, s2_fold[15:0]} + {16'd0, s2_fold[16]};
    sum_good   = (fold_final[15:0] == icmpchk_pkg::SUM_ALL_ONES);
    good_next  = 1'b0;
    if (s2_short) begin
      status_next = icmpchk_pkg::STATUS_TOO_SHORT;
    end else if (!sum_good) begin
      status_next = icmpchk_pkg::STATUS_BAD_SUM;
    end else if (s2_type != icmpchk_pkg::ECHO_REPLY_TYPE) begin
      status_next = icmpchk_pkg::STATUS_NOT_REPLY;
    end else if (s2_ident != own_identifier) begin
      status_next = icmpchk_pkg::STATUS_FOREIGN_ID;
    end else begin
      status_next = icmpchk_pkg::STATUS_OK;
      good_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      good_count   <= '0;
      minimum_trip <= icmpchk_pkg::MIN_TRIP_RESET;
      maximum_trip <= '0;
      total_trip   <= '0;
    end else if (!stall) begin
      out_valid <= s2_valid;
      if (s2_valid && good_next) begin
        good_count <= good_count + 32'd1;
        total_trip <= total_trip + s2_trip;
        if (minimum_trip > s2_trip) begin
          minimum_trip <= s2_trip;
        end
        if (maximum_trip < s2_trip) begin
          maximum_trip <= s2_trip;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      status         <= status_next;
      reply_type     <= s2_type;
      sequence_res   <= s2_seq;
      round_trip_ms  <= good_next ? s2_trip : 32'd0;
      payload_length <= s2_payload;
    end
  end

  // statistics only move when a result is loaded, so they hold under stall
  assign replies_received    = good_count;
  assign least_round_trip    = minimum_trip;
  assign greatest_round_trip = maximum_trip;
  assign summed_round_trip   = total_trip;

  `ICMPCHK_ASSERT_NEXT(a_parse_cleared, clk, rst, in_xfer && last_byte,
                       byte_position == 16'd0 && sum_accumulator == 32'd0)
  `ICMPCHK_ASSERT_NEXT(a_good_counts, clk, rst, !stall && s2_valid && good_next,
                       good_count == $past(good_count) + 32'd1)
  `ICMPCHK_ASSERT_NEXT(a_stall_holds_pipe, clk, rst, stall,
                       s1_valid == $past(s1_valid) && s2_valid == $past(s2_valid))
  `ICMPCHK_ASSERT_SAME(a_min_not_above_max, clk, rst, good_count != 32'd0,
                       minimum_trip <= maximum_trip)
  `ICMPCHK_ASSERT_SAME(a_ok_has_trip, clk, rst,
                       out_valid && status != icmpchk_pkg::STATUS_OK,
                       round_trip_ms == 32'd0)

endmodule

>>> dv/icmp_echo_reply_checker_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the icmp echo reply checker: packet stimulus, prediction, checks
module icmp_echo_reply_checker_test;

  typedef struct {
    icmpchk_pkg::status_t status;
    logic [7:0]  kind;
    logic [15:0] seq;
    logic [31:0] trip;
    logic [15:0] payload;
    logic [31:0] count;
    logic [31:0] least;
    logic [31:0] greatest;
    logic [31:0] summed;
  } reply_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  reply_type;
  logic [15:0] sequence_res;
  logic [31:0] round_trip_ms;
  logic [15:0] payload_length;
  logic [31:0] replies_received;
  logic [31:0] least_round_trip;
  logic [31:0] greatest_round_trip;
  logic [31:0] summed_round_trip;

  icmp_echo_reply_checker DUT (.*);

  // parse and statistics state of the predicted checker
  logic [15:0] byte_count;
  logic [5:0]  ip_header_len;
  logic [15:0] ip_total_len;
  logic [31:0] word_sum;
  logic [7:0]  even_byte;
  logic [7:0]  icmp_kind;
  logic [15:0] icmp_ident;
  logic [15:0] echo_seq;
  logic [31:0] icmp_stamp;
  logic [31:0] good_replies;
  logic [31:0] least_trip;
  logic [31:0] greatest_trip;
  logic [31:0] trip_total;
  logic [15:0] own_ident;

  reply_report_t pending_reports[$];
  logic [7:0]    frame[$];
  int unsigned   bytes_sent = 0;
  int unsigned   reports_made = 0;
  int unsigned   mismatches = 0;
  int unsigned   gap_pct = 0;
  int unsigned   stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic forget_packet();
    byte_count    = '0;
    ip_header_len = '0;
    ip_total_len  = '0;
    word_sum      = '0;
    even_byte     = '0;
    icmp_kind     = '0;
    icmp_ident    = '0;
    echo_seq      = '0;
    icmp_stamp    = '0;
  endtask

  task automatic follow_byte(input logic [7:0] b, input logic last, input logic [31:0] now);
    int unsigned   pos;
    int unsigned   off;
    logic [31:0]   folded;
    reply_report_t rep;
    pos = 32'(byte_count);
    if (pos == 0) ip_header_len = {b[3:0], 2'b00};
    if (pos == 2) ip_total_len[15:8] = b;
    if (pos == 3) ip_total_len[7:0] = b;
    // the first four bytes always belong to the icmp part once past the header
    if (pos >= ip_header_len && (pos < 4 || pos < ip_total_len)) begin
      off = pos - ip_header_len;
      if (off[0]) word_sum = word_sum + {16'h0000, even_byte, b};
      else even_byte = b;
      case (off)
        icmpchk_pkg::OFF_TYPE:   icmp_kind = b;
        icmpchk_pkg::OFF_ID_LO:  icmp_ident[7:0] = b;
        icmpchk_pkg::OFF_ID_HI:  icmp_ident[15:8] = b;
        icmpchk_pkg::OFF_SEQ_LO: echo_seq[7:0] = b;
        icmpchk_pkg::OFF_SEQ_HI: echo_seq[15:8] = b;
        default: begin
          if (off >= icmpchk_pkg::OFF_TS_FIRST && off <= icmpchk_pkg::OFF_TS_LAST)
            icmp_stamp[8 * (off - icmpchk_pkg::OFF_TS_FIRST) +: 8] = b;
        end
      endcase
    end
    if (byte_count != icmpchk_pkg::POSITION_MAX) byte_count = byte_count + 16'd1;
    if (last) begin
      rep.kind    = icmp_kind;
      rep.seq     = echo_seq;
      rep.trip    = '0;
      rep.payload = '0;
      if (ip_total_len < ip_header_len + icmpchk_pkg::ECHO_HEADER_LEN ||
          pos + 1 < ip_total_len) begin
        rep.status = icmpchk_pkg::STATUS_TOO_SHORT;
      end else begin
        rep.payload = 16'(ip_total_len - ip_header_len - icmpchk_pkg::ECHO_HEADER_LEN);
        folded = word_sum;
        // header length is a multiple of four, so the icmp part is odd when the total is
        if (ip_total_len[0]) folded = folded + {16'h0000, even_byte, 8'h00};
        folded = (folded >> 16) + {16'h0000, folded[15:0]};
        folded = folded + (folded >> 16);
        if (folded[15:0] != icmpchk_pkg::SUM_ALL_ONES) begin
          rep.status = icmpchk_pkg::STATUS_BAD_SUM;
        end else if (icmp_kind != icmpchk_pkg::ECHO_REPLY_TYPE) begin
          rep.status = icmpchk_pkg::STATUS_NOT_REPLY;
        end else if (icmp_ident != own_ident) begin
          rep.status = icmpchk_pkg::STATUS_FOREIGN_ID;
        end else begin
          rep.status   = icmpchk_pkg::STATUS_OK;
          rep.trip     = now - icmp_stamp;
          good_replies = good_replies + 32'd1;
          trip_total   = trip_total + rep.trip;
          if (least_trip > rep.trip) least_trip = rep.trip;
          if (greatest_trip < rep.trip) greatest_trip = rep.trip;
        end
      end
      rep.count    = good_replies;
      rep.least    = least_trip;
      rep.greatest = greatest_trip;
      rep.summed   = trip_total;
      pending_reports.push_back(rep);
      reports_made++;
      forget_packet();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    reply_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result, status", {29'd0, status}, '0);
      end else begin
        want = pending_reports.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (reply_type !== want.kind)
          report_mismatch("reply_type", 32'(reply_type), 32'(want.kind));
        if (sequence_res !== want.seq)
          report_mismatch("sequence_res", 32'(sequence_res), 32'(want.seq));
        if (round_trip_ms !== want.trip)
          report_mismatch("round_trip_ms", round_trip_ms, want.trip);
        if (payload_length !== want.payload)
          report_mismatch("payload_length", 32'(payload_length), 32'(want.payload));
        if (replies_received !== want.count)
          report_mismatch("replies_received", replies_received, want.count);
        if (least_round_trip !== want.least)
          report_mismatch("least_round_trip", least_round_trip, want.least);
        if (greatest_round_trip !== want.greatest)
          report_mismatch("greatest_round_trip", greatest_round_trip, want.greatest);
        if (summed_round_trip !== want.summed)
          report_mismatch("summed_round_trip", summed_round_trip, want.summed);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] now);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    now_ms    <= now;
    do @(posedge clk); while (!in_ready);
    follow_byte(b, last, now);
    bytes_sent++;
  endtask

  // now_ms only matters on the last byte, the others carry noise
  task automatic send_frame(input logic [31:0] now);
    for (int i = 0; i < frame.size(); i++) begin
      if (i == frame.size() - 1) send_byte(frame[i], 1'b1, now);
      else send_byte(frame[i], 1'b0, $urandom());
    end
  endtask

  // wait until every result is in, then let the pipeline run empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_own_id(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    own_ident = value;
  endtask

  // fills frame with an ip packet carrying an icmp echo message of the given type with a correct checksum
  task automatic build_echo(input logic [3:0] ihl, input int unsigned echo_len,
                            input logic [7:0] kind, input logic [15:0] ident,
                            input logic [15:0] seq, input logic [31:0] stamp);
    int unsigned hdr;
    int unsigned total;
    int unsigned fix;
    logic [31:0] acc;
    hdr = ihl * 4;
    // with no ip header, bytes 2-3 are the length, so the sum is balanced in the payload
    if (hdr == 0 && echo_len < 14) echo_len = 14;
    if (hdr == 0) kind[3:0] = 4'h0;
    fix = (hdr == 0) ? 12 : 2;
    total = hdr + echo_len;
    frame.delete();
    for (int i = 0; i < total; i++) frame.push_back(8'($urandom()));
    frame[0] = (frame[0] & 8'hf0) | {4'h0, ihl};
    frame[2] = total[15:8];
    frame[3] = total[7:0];
    frame[hdr + icmpchk_pkg::OFF_TYPE]   = kind;
    frame[hdr + icmpchk_pkg::OFF_ID_LO]  = ident[7:0];
    frame[hdr + icmpchk_pkg::OFF_ID_HI]  = ident[15:8];
    frame[hdr + icmpchk_pkg::OFF_SEQ_LO] = seq[7:0];
    frame[hdr + icmpchk_pkg::OFF_SEQ_HI] = seq[15:8];
    for (int k = 0; k < 4; k++) begin
      if (icmpchk_pkg::OFF_TS_FIRST + k < echo_len)
        frame[hdr + icmpchk_pkg::OFF_TS_FIRST + k] = stamp[8 * k +: 8];
    end
    frame[hdr + fix]     = 8'h00;
    frame[hdr + fix + 1] = 8'h00;
    acc = '0;
    for (int i = 0; i < echo_len; i++)
      acc = acc + (i[0] ? {24'h0, frame[hdr + i]} : {16'h0, frame[hdr + i], 8'h00});
    acc = (acc >> 16) + (acc & 32'hffff);
    acc = (acc >> 16) + (acc & 32'hffff);
    frame[hdr + fix]     = ~acc[15:8];
    frame[hdr + fix + 1] = ~acc[7:0];
  endtask

  task automatic random_frame();
    logic [3:0]  ihl;
    logic [31:0] stamp;
    logic [31:0] now;
    logic [15:0] ident;
    logic [7:0]  kind;
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(99);
    ihl = (pick < 40) ? 4'd5 : (pick < 65) ? 4'd0 :
          (pick < 90) ? 4'($urandom_range(2, 1)) : 4'($urandom_range(15));
    ident = ($urandom_range(99) < 85) ? own_ident : 16'($urandom());
    kind = ($urandom_range(99) < 85) ? icmpchk_pkg::ECHO_REPLY_TYPE : 8'($urandom());
    stamp = $urandom();
    now = ($urandom_range(1) != 0) ? stamp + $urandom_range(2000) : $urandom();
    build_echo(ihl, 8 + $urandom_range(12), kind, ident, 16'($urandom()), stamp);
    pick = $urandom_range(99);
    if (pick < 6) begin
      // ends before its total length
      cut = $urandom_range(frame.size() - 1, 1);
      repeat (cut) void'(frame.pop_back());
    end else if (pick < 12) begin
      repeat ($urandom_range(6, 1)) frame.push_back(8'($urandom()));
    end else if (pick < 18) begin
      cut = $urandom_range(frame.size() - 1);
      frame[cut] = frame[cut] ^ (8'h01 << $urandom_range(7));
    end else if (pick < 23) begin
      cut = $urandom_range(ihl * 4 + 7);
      frame[2] = cut[15:8];
      frame[3] = cut[7:0];
    end else if (pick < 28) begin
      frame.delete();
      repeat ($urandom_range(40, 1)) frame.push_back(8'($urandom()));
    end
    send_frame(now);
  endtask

  task automatic test_echo_replies();
    settle();
    write_own_id(16'h0000);
    // no ip header: the icmp part overlaps the version and length bytes
    build_echo(4'd0, 14, icmpchk_pkg::ECHO_REPLY_TYPE, 16'h0000, 16'h0000, 32'h0000_0000);
    send_frame(32'd40000);
    // odd icmp length, last byte padded with zero; timestamp wraps
    build_echo(4'd1, 13, icmpchk_pkg::ECHO_REPLY_TYPE, 16'h0000, 16'hffff, 32'hffff_ffff);
    send_frame(32'd299);
    // timestamp cut short, missing bytes read as zero
    build_echo(4'd1, 9, icmpchk_pkg::ECHO_REPLY_TYPE, 16'h0000, 16'h1234, $urandom());
    send_frame($urandom());
    settle();
    write_own_id(16'hffff);
    build_echo(4'd15, 8, icmpchk_pkg::ECHO_REPLY_TYPE, 16'hffff, 16'h8001, 32'd0);
    send_frame(32'd1);
  endtask

  task automatic test_rejections();
    build_echo(4'd1, 8, icmpchk_pkg::ECHO_REPLY_TYPE, 16'h0000, 16'h0101, $urandom());
    send_frame(32'd0);
    build_echo(4'd1, 8, 8'd8, own_ident, 16'h0202, $urandom());
    send_frame($urandom());
    build_echo(4'd2, 12, 8'hff, own_ident, 16'h0303, $urandom());
    send_frame($urandom());
    build_echo(4'd1, 10, icmpchk_pkg::ECHO_REPLY_TYPE, own_ident, 16'h0404, $urandom());
    frame[frame.size() - 1] = frame[frame.size() - 1] ^ 8'h01;
    send_frame($urandom());
    // all-zero icmp part, its sum folds to zero
    build_echo(4'd1, 8, icmpchk_pkg::ECHO_REPLY_TYPE, own_ident, 16'h0000, 32'd0);
    for (int i = 4; i < 12; i++) frame[i] = 8'h00;
    send_frame($urandom());
    // total length one below header plus icmp header
    build_echo(4'd1, 8, icmpchk_pkg::ECHO_REPLY_TYPE, own_ident, 16'h0505, $urandom());
    frame[2] = 8'd0;
    frame[3] = 8'd11;
    send_frame($urandom());
    build_echo(4'd1, 12, icmpchk_pkg::ECHO_REPLY_TYPE, own_ident, 16'h0606, $urandom());
    void'(frame.pop_back());
    send_frame($urandom());
    // bytes past the total length are ignored
    build_echo(4'd1, 8, icmpchk_pkg::ECHO_REPLY_TYPE, own_ident, 16'h0707, $urandom());
    repeat (3) frame.push_back(8'($urandom()));
    send_frame(32'd65000);
    frame.delete();
    frame.push_back(8'hff);
    send_frame(32'hffff_ffff);
  endtask

  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall);
    int unsigned first_byte;
    settle();
    write_own_id(16'($urandom()));
    gap_pct = gap;
    stall_pct = stall;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < 100) random_frame();
  endtask

  initial begin
    forget_packet();
    good_replies  = '0;
    least_trip    = icmpchk_pkg::MIN_TRIP_RESET;
    greatest_trip = '0;
    trip_total    = '0;
    own_ident     = '0;
    gap_pct       = 6;
    stall_pct     = 57;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_echo_replies();
    test_rejections();
    test_random_traffic(6, 57);
    test_random_traffic(57, 6);
    test_random_traffic(0, 0);
    settle();
    if (mismatches == 0) begin
      $display("** icmp_echo_reply_checker: PASSED **");
    end else begin
      $display("** icmp_echo_reply_checker: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: results still outstanding");
    $display("** icmp_echo_reply_checker: FAILED **");
    $finish;
  end

endmodule
